// ----- design/assert_macros.svh -----
// Assertion macros shared by the quaternion unit.
// No dependencies; the body is left empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define QMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define QMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/qmn_pkg.sv -----
// Package for the quaternion unit: widths, opcodes and the data carried
// along the square-root and divider cell rows. No dependencies.
`timescale 1ns / 1ps
package qmn_pkg;
	localparam int FRAC_BITS = 14;
	localparam int RAW_W     = 34;
	localparam int ABS_W     = 33;
	localparam int MAG_W     = 30;
	localparam int SQR_W     = 2 * MAG_W;
	localparam int SUM_W     = SQR_W + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int SQ_REM_W  = ROOT_W + 1;
	localparam int SQ_N      = ROOT_W;
	localparam int NUM_W     = MAG_W + 1 + FRAC_BITS;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int DREM_W    = ROOT_W;
	localparam int LIM_INT   = ((2 ** FRAC_BITS) > 32767) ? 32767 : (2 ** FRAC_BITS);
	localparam logic [31:0] LIM = 32'(LIM_INT);

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_ADD  = 2'd1,
		OP_NORM = 2'd2,
		OP_INV  = 2'd3
	} op_t;

	// Side data that rides along the square-root row.
	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic                  zero;
		logic                  inv;
	} sq_side_t;

	// Side data that rides along the divider row.
	typedef struct packed {
		logic [ROOT_W-1:0] len;
		logic [3:0]        neg;
		logic              zero;
		logic              inv;
	} dv_side_t;
endpackage

// ----- design/qmn_sqrt_cell.sv -----
// One step of the bit-by-bit integer square root: one result bit per cell.
// Depends on qmn_pkg.
`timescale 1ns / 1ps
module qmn_sqrt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [qmn_pkg::SUM_W-1:0]    rad_in,
	input  logic [qmn_pkg::SQ_REM_W-1:0] rem_in,
	input  logic [qmn_pkg::ROOT_W-1:0]   root_in,
	input  qmn_pkg::sq_side_t            side_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [qmn_pkg::SUM_W-1:0]    rad_out,
	output logic [qmn_pkg::SQ_REM_W-1:0] rem_out,
	output logic [qmn_pkg::ROOT_W-1:0]   root_out,
	output qmn_pkg::sq_side_t            side_out
);
	import qmn_pkg::*;

	logic                  valid_q;
	logic [SQ_REM_W+1:0]   cur;
	logic [SQ_REM_W+1:0]   trial;
	logic                  ge;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Bring down the next two radicand bits and try the next root bit.
	assign cur   = {rem_in, rad_in[SUM_W-1 -: 2]};
	assign trial = {1'b0, root_in, 2'b01};
	assign ge    = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			rad_out  <= {rad_in[SUM_W-3:0], 2'b00};
			rem_out  <= ge ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
			root_out <= {root_in[ROOT_W-2:0], ge};
			side_out <= side_in;
		end
	end
endmodule

// ----- design/qmn_div_cell.sv -----
// One restoring division step for all four lanes: one quotient bit per cell.
// Depends on qmn_pkg.
`timescale 1ns / 1ps
module qmn_div_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [3:0][qmn_pkg::DREM_W-1:0]     rem_in,
	input  logic [3:0][qmn_pkg::QUO_W-1:0]      qd_in,
	input  qmn_pkg::dv_side_t                   side_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [3:0][qmn_pkg::DREM_W-1:0]     rem_out,
	output logic [3:0][qmn_pkg::QUO_W-1:0]      qd_out,
	output qmn_pkg::dv_side_t                   side_out
);
	import qmn_pkg::*;

	logic                          valid_q;
	logic [3:0][DREM_W:0]          cur;
	logic [3:0]                    ge;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Shift the next dividend bit into each partial remainder and compare.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur[i] = {rem_in[i], qd_in[i][QUO_W-1]};
			ge[i]  = (cur[i] >= {1'b0, side_in.len});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			for (int i = 0; i < 4; i++) begin
				rem_out[i] <= ge[i] ? DREM_W'(cur[i] - {1'b0, side_in.len})
				                    : cur[i][DREM_W-1:0];
				qd_out[i]  <= {qd_in[i][QUO_W-2:0], ge[i]};
			end
			side_out <= side_in;
		end
	end
endmodule

// ----- design/quaternion_multiply_normalize.sv -----
// Quaternion product, sum, normalize and inverse with unit-length results.
// Pipeline: 6 front stages, 31 square-root cells, 1 divider set-up stage,
// FRAC_BITS+1 divider cells and 1 output register; data is Q1.14.
// One transaction per cycle unless back-pressured; stages stall only if full.
// Reset: arst_n clears all valid flags at once; data registers are not reset.
// Depends on qmn_pkg, qmn_sqrt_cell, qmn_div_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_multiply_normalize (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] a_w,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_w,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] r_w,
	output logic signed [15:0] r_x,
	output logic signed [15:0] r_y,
	output logic signed [15:0] r_z,
	output logic               zero_length
);
	import qmn_pkg::*;

	localparam int DV_N = QUO_W;

	// Stage valid flags and the ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_d0, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_d0, rdy_out;

	logic [SQ_N:0]                 sq_v, sq_r;
	logic [SQ_N:0][SUM_W-1:0]      sq_rad;
	logic [SQ_N:0][SQ_REM_W-1:0]   sq_rem;
	logic [SQ_N:0][ROOT_W-1:0]     sq_root;
	sq_side_t [SQ_N:0]             sq_side;

	logic [DV_N:0]                 dv_v, dv_r;
	logic [DV_N:0][3:0][DREM_W-1:0] dv_rem;
	logic [DV_N:0][3:0][QUO_W-1:0]  dv_qd;
	dv_side_t [DV_N:0]             dv_side;

	// Divider set-up registers.
	logic [3:0][DREM_W-1:0]        dv0_rem_q;
	logic [3:0][QUO_W-1:0]         dv0_qd_q;
	dv_side_t                      dv0_side_q;

	// Stage 1: the sixteen partial products and the plain sums or operand a.
	logic signed [15:0][31:0] p_s1;
	logic signed [3:0][16:0]  addv_s1;
	logic [1:0]               op_s1;

	// Stage 2: raw components.
	logic signed [3:0][RAW_W-1:0] c_s2;
	logic [1:0]                   op_s2;

	// Stage 3: magnitudes and leading-one position.
	logic [3:0][ABS_W-1:0] mag_s3;
	logic [3:0]            neg_s3;
	logic [5:0]            pos_s3;
	logic                  zero_s3, inv_s3;

	// Stage 4: scaled magnitudes; stage 5: squares; stage 6: sum of squares.
	sq_side_t              side_s4, side_s5, side_s6;
	logic [3:0][SQR_W-1:0] sq_s5;
	logic [SUM_W-1:0]      sum_s6;

	logic [ABS_W-1:0]      orv;
	logic [5:0]            pos_c;
	logic [3:0][ABS_W-1:0] mag_c;
	logic [3:0][ABS_W-1:0] scl_c;
	logic [3:0][NUM_W-1:0] num_c;

	logic signed [15:0]    r_q [4];
	logic                  zero_q;
	logic [3:0][31:0]      qx;
	logic [3:0][15:0]      qc;

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy_d0  = !v_d0 || dv_r[0];
	assign rdy6    = !v_s6 || sq_r[0];
	assign rdy5    = !v_s5 || rdy6;
	assign rdy4    = !v_s4 || rdy5;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_d0 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy_d0) v_d0 <= sq_v[SQ_N];
			if (rdy_out) out_valid_q <= dv_v[DV_N];
		end
	end

	// Products of the operands, and their sums or operand a.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			p_s1[0]  <= a_w * b_w;
			p_s1[1]  <= a_x * b_x;
			p_s1[2]  <= a_y * b_y;
			p_s1[3]  <= a_z * b_z;
			p_s1[4]  <= a_w * b_x;
			p_s1[5]  <= a_x * b_w;
			p_s1[6]  <= a_y * b_z;
			p_s1[7]  <= a_z * b_y;
			p_s1[8]  <= a_w * b_y;
			p_s1[9]  <= a_y * b_w;
			p_s1[10] <= a_x * b_z;
			p_s1[11] <= a_z * b_x;
			p_s1[12] <= a_w * b_z;
			p_s1[13] <= a_z * b_w;
			p_s1[14] <= a_x * b_y;
			p_s1[15] <= a_y * b_x;
			if (opcode == OP_ADD) begin
				addv_s1[0] <= 17'(a_w) + 17'(b_w);
				addv_s1[1] <= 17'(a_x) + 17'(b_x);
				addv_s1[2] <= 17'(a_y) + 17'(b_y);
				addv_s1[3] <= 17'(a_z) + 17'(b_z);
			end else begin
				addv_s1[0] <= 17'(a_w);
				addv_s1[1] <= 17'(a_x);
				addv_s1[2] <= 17'(a_y);
				addv_s1[3] <= 17'(a_z);
			end
			op_s1 <= opcode;
		end
	end

	// Raw components of the Hamilton product, or the sum or operand.
	// Elements of a packed array read as unsigned, so each is sign-extended here.
	always_ff @(posedge clk) begin
		if (rdy2) begin
			if (op_s1 == OP_MUL) begin
				c_s2[0] <= RAW_W'($signed(p_s1[0])) - RAW_W'($signed(p_s1[1]))
				           - RAW_W'($signed(p_s1[2])) - RAW_W'($signed(p_s1[3]));
				c_s2[1] <= RAW_W'($signed(p_s1[4])) + RAW_W'($signed(p_s1[5]))
				           + RAW_W'($signed(p_s1[6])) - RAW_W'($signed(p_s1[7]));
				c_s2[2] <= RAW_W'($signed(p_s1[8])) + RAW_W'($signed(p_s1[9]))
				           - RAW_W'($signed(p_s1[10])) + RAW_W'($signed(p_s1[11]));
				c_s2[3] <= RAW_W'($signed(p_s1[12])) + RAW_W'($signed(p_s1[13]))
				           + RAW_W'($signed(p_s1[14])) - RAW_W'($signed(p_s1[15]));
			end else begin
				for (int i = 0; i < 4; i++) c_s2[i] <= RAW_W'($signed(addv_s1[i]));
			end
			op_s2 <= op_s1;
		end
	end

	// Magnitudes, signs and the position of the leading one.
	always_comb begin
		orv = '0;
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = c_s2[i][RAW_W-1] ? ABS_W'(-c_s2[i]) : ABS_W'(c_s2[i]);
			orv      = orv | mag_c[i];
		end
		pos_c = '0;
		for (int b = 0; b < ABS_W; b++) begin
			if (orv[b]) pos_c = 6'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			mag_s3 <= mag_c;
			for (int i = 0; i < 4; i++) neg_s3[i] <= c_s2[i][RAW_W-1];
			pos_s3  <= pos_c;
			zero_s3 <= (orv == '0);
			inv_s3  <= (op_s2 == OP_INV);
		end
	end

	// Scale so that the largest magnitude has its top bit at bit 29.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (pos_s3 >= 6'(MAG_W - 1)) begin
				scl_c[i] = mag_s3[i] >> (pos_s3 - 6'(MAG_W - 1));
			end else begin
				scl_c[i] = mag_s3[i] << (6'(MAG_W - 1) - pos_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int i = 0; i < 4; i++) side_s4.mag[i] <= scl_c[i][MAG_W-1:0];
			side_s4.neg  <= neg_s3;
			side_s4.zero <= zero_s3;
			side_s4.inv  <= inv_s3;
		end
	end

	// Squares, then their sum.
	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int i = 0; i < 4; i++) sq_s5[i] <= side_s4.mag[i] * side_s4.mag[i];
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6) begin
			sum_s6 <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2])
			          + SUM_W'(sq_s5[3]);
			side_s6 <= side_s5;
		end
	end

	// Row of square-root cells.
	assign sq_v[0]    = v_s6;
	assign sq_rad[0]  = sum_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s6;
	assign sq_r[SQ_N] = rdy_d0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		qmn_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[k]),
			.in_ready  (sq_r[k]),
			.rad_in    (sq_rad[k]),
			.rem_in    (sq_rem[k]),
			.root_in   (sq_root[k]),
			.side_in   (sq_side[k]),
			.out_valid (sq_v[k+1]),
			.out_ready (sq_r[k+1]),
			.rad_out   (sq_rad[k+1]),
			.rem_out   (sq_rem[k+1]),
			.root_out  (sq_root[k+1]),
			.side_out  (sq_side[k+1])
		);
	end

	// Divider set-up: rounded dividend, split into the starting remainder
	// and the bits still to be brought down.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num_c[i] = {1'b0, sq_side[SQ_N].mag[i], {FRAC_BITS{1'b0}}}
			           + NUM_W'(sq_root[SQ_N] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_d0) begin
			for (int i = 0; i < 4; i++) begin
				dv0_rem_q[i] <= DREM_W'(num_c[i][NUM_W-1:QUO_W]);
				dv0_qd_q[i]  <= num_c[i][QUO_W-1:0];
			end
			dv0_side_q.len  <= sq_root[SQ_N];
			dv0_side_q.neg  <= sq_side[SQ_N].neg;
			dv0_side_q.zero <= sq_side[SQ_N].zero;
			dv0_side_q.inv  <= sq_side[SQ_N].inv;
		end
	end

	// Row of divider cells.
	assign dv_v[0]    = v_d0;
	assign dv_rem[0]  = dv0_rem_q;
	assign dv_qd[0]   = dv0_qd_q;
	assign dv_side[0] = dv0_side_q;
	assign dv_r[DV_N] = rdy_out;

	for (genvar k = 0; k < DV_N; k++) begin : g_dv
		qmn_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[k]),
			.in_ready  (dv_r[k]),
			.rem_in    (dv_rem[k]),
			.qd_in     (dv_qd[k]),
			.side_in   (dv_side[k]),
			.out_valid (dv_v[k+1]),
			.out_ready (dv_r[k+1]),
			.rem_out   (dv_rem[k+1]),
			.qd_out    (dv_qd[k+1]),
			.side_out  (dv_side[k+1])
		);
	end

	// Clamp, restore signs and apply the conjugate for the inverse.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qx[i] = 32'(dv_qd[DV_N][i]);
			qc[i] = (qx[i] > LIM) ? LIM[15:0] : qx[i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			for (int i = 0; i < 4; i++) begin
				if (dv_side[DV_N].zero) begin
					r_q[i] <= '0;
				end else if (dv_side[DV_N].neg[i] ^ (dv_side[DV_N].inv && (i != 0))) begin
					r_q[i] <= -$signed(qc[i]);
				end else begin
					r_q[i] <= $signed(qc[i]);
				end
			end
			zero_q <= dv_side[DV_N].zero;
		end
	end

	assign out_valid   = out_valid_q;
	assign r_w         = r_q[0];
	assign r_x         = r_q[1];
	assign r_y         = r_q[2];
	assign r_z         = r_q[3];
	assign zero_length = zero_q;

	`QMN_ASSERT_NOW(a_zero_out, clk, arst_n, out_valid && zero_length, r_w == 0 && r_x == 0 && r_y == 0 && r_z == 0, "zero-length result has a nonzero component")
	`QMN_ASSERT_NOW(a_unit_nonzero, clk, arst_n, out_valid && !zero_length, r_w != 0 || r_x != 0 || r_y != 0 || r_z != 0, "unit result has all components zero")
	`QMN_ASSERT_NOW(a_range, clk, arst_n, out_valid, $signed(r_w) <= $signed(LIM) && $signed(r_w) >= -$signed(LIM), "scalar part beyond one")
	`QMN_ASSERT_NOW(a_empty_ready, clk, arst_n, !out_valid, in_ready, "input stalled with an empty output register")
endmodule
